// ----- hw/rtl/saes_pkg.sv -----
// types, tables and round functions for the simplified aes block cipher
package saes_pkg;

  typedef enum logic [1:0] {
    OP_ENC    = 2'd0,
    OP_DEC    = 2'd1,
    OP_DOUBLE = 2'd2,
    OP_TRIPLE = 2'd3
  } op_t;

  // register index taken from paddr[2]
  localparam logic REG_KEY_FIRST  = 1'b0;
  localparam logic REG_KEY_SECOND = 1'b1;

  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned BLOCK_W = 16;

  localparam logic [7:0] RCON_1 = 8'h80;
  localparam logic [7:0] RCON_2 = 8'h30;

  localparam logic [3:0] MIX_DIAG     = 4'h1;
  localparam logic [3:0] MIX_OFF      = 4'h4;
  localparam logic [3:0] INV_MIX_DIAG = 4'h9;
  localparam logic [3:0] INV_MIX_OFF  = 4'h2;

  typedef struct packed {
    logic [BLOCK_W-1:0] k0;
    logic [BLOCK_W-1:0] k1;
    logic [BLOCK_W-1:0] k2;
  } round_keys_t;

  function automatic logic [3:0] sbox_fwd(input logic [3:0] n);
    logic [3:0] r;
    case (n)
      4'h0: r = 4'h9;
      4'h1: r = 4'h4;
      4'h2: r = 4'hA;
      4'h3: r = 4'hB;
      4'h4: r = 4'hD;
      4'h5: r = 4'h1;
      4'h6: r = 4'h8;
      4'h7: r = 4'h5;
      4'h8: r = 4'h6;
      4'h9: r = 4'h2;
      4'hA: r = 4'h0;
      4'hB: r = 4'h3;
      4'hC: r = 4'hC;
      4'hD: r = 4'hE;
      4'hE: r = 4'hF;
      default: r = 4'h7;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] sbox_inv(input logic [3:0] n);
    logic [3:0] r;
    case (n)
      4'h0: r = 4'hA;
      4'h1: r = 4'h5;
      4'h2: r = 4'h9;
      4'h3: r = 4'hB;
      4'h4: r = 4'h1;
      4'h5: r = 4'h7;
      4'h6: r = 4'h8;
      4'h7: r = 4'hF;
      4'h8: r = 4'h6;
      4'h9: r = 4'h0;
      4'hA: r = 4'h2;
      4'hB: r = 4'h3;
      4'hC: r = 4'hC;
      4'hD: r = 4'h4;
      4'hE: r = 4'hD;
      default: r = 4'hE;
    endcase
    return r;
  endfunction

  // multiply in gf(2^4) modulo x^4+x+1
  function automatic logic [3:0] gf_mul(input logic [3:0] a, input logic [3:0] b);
    logic [3:0] acc;
    logic [4:0] x;
    acc = 4'h0;
    x = {1'b0, a};
    for (int i = 0; i < 4; i++) begin
      if (b[i]) begin
        acc = acc ^ x[3:0];
      end
      x = {x[3:0], 1'b0};
      if (x[4]) begin
        x = x ^ 5'h13;
      end
    end
    return acc;
  endfunction

  function automatic logic [BLOCK_W-1:0] sub_fwd(input logic [BLOCK_W-1:0] s);
    return {sbox_fwd(s[15:12]), sbox_fwd(s[11:8]), sbox_fwd(s[7:4]), sbox_fwd(s[3:0])};
  endfunction

  function automatic logic [BLOCK_W-1:0] sub_inv(input logic [BLOCK_W-1:0] s);
    return {sbox_inv(s[15:12]), sbox_inv(s[11:8]), sbox_inv(s[7:4]), sbox_inv(s[3:0])};
  endfunction

  // swap nibbles 1 and 3
  function automatic logic [BLOCK_W-1:0] shift_rows(input logic [BLOCK_W-1:0] s);
    return {s[15:12], s[3:0], s[7:4], s[11:8]};
  endfunction

  function automatic logic [BLOCK_W-1:0] mix_cols(input logic [BLOCK_W-1:0] s,
                                                  input logic [3:0] diag,
                                                  input logic [3:0] off);
    logic [3:0] m0, m1, m2, m3;
    m0 = gf_mul(diag, s[15:12]) ^ gf_mul(off, s[11:8]);
    m1 = gf_mul(off, s[15:12]) ^ gf_mul(diag, s[11:8]);
    m2 = gf_mul(diag, s[7:4]) ^ gf_mul(off, s[3:0]);
    m3 = gf_mul(off, s[7:4]) ^ gf_mul(diag, s[3:0]);
    return {m0, m1, m2, m3};
  endfunction

  function automatic logic [7:0] g_func(input logic [7:0] w, input logic [7:0] rcon);
    logic [7:0] rot;
    rot = {w[3:0], w[7:4]};
    return rcon ^ {sbox_fwd(rot[7:4]), sbox_fwd(rot[3:0])};
  endfunction

  function automatic round_keys_t expand_key(input logic [BLOCK_W-1:0] k);
    round_keys_t rk;
    logic [7:0] w2, w3, w4, w5;
    w2 = k[15:8] ^ g_func(k[7:0], RCON_1);
    w3 = w2 ^ k[7:0];
    w4 = w2 ^ g_func(w3, RCON_2);
    w5 = w4 ^ w3;
    rk.k0 = k;
    rk.k1 = {w2, w3};
    rk.k2 = {w4, w5};
    return rk;
  endfunction

  function automatic logic [BLOCK_W-1:0] encrypt(input logic [BLOCK_W-1:0] p,
                                                 input round_keys_t rk);
    logic [BLOCK_W-1:0] s;
    s = p ^ rk.k0;
    s = mix_cols(shift_rows(sub_fwd(s)), MIX_DIAG, MIX_OFF);
    s = s ^ rk.k1;
    s = shift_rows(sub_fwd(s));
    return s ^ rk.k2;
  endfunction

  function automatic logic [BLOCK_W-1:0] decrypt(input logic [BLOCK_W-1:0] c,
                                                 input round_keys_t rk);
    logic [BLOCK_W-1:0] s;
    s = c ^ rk.k2;
    s = sub_inv(shift_rows(s));
    s = s ^ rk.k1;
    s = mix_cols(s, INV_MIX_DIAG, INV_MIX_OFF);
    s = sub_inv(shift_rows(s));
    return s ^ rk.k0;
  endfunction

endpackage

// ----- hw/rtl/simplified_aes_block_cipher.sv -----
// 16-bit simplified aes block cipher: single, double and triple modes, one beat per cycle unless stalled
//
// Takes one beat per clock when the result side keeps up; each beat passes first through the
// input register and then the result register. All cipher passes of a beat, up to three for
// the encrypt-decrypt-encrypt opcode, sit in one combinational layer between those two
// registers. Round keys are expanded when a key register is written, so the
// key schedule is off the data path; a key write applies to every beat not yet in the result
// register, so keys are best written with the block empty. With the
// result side stalled the block still holds one more beat in its input register before it
// raises in_stall. Keys live at byte address 0 (key_first) and 4 (key_second); paddr[1:0] is
// ignored and reads return the key in the low 16 bits.
module simplified_aes_block_cipher (
  input  logic                           clk,
  input  logic                           rst,
  // apb-style configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [saes_pkg::ADDR_W-1:0]    paddr,
  input  logic [saes_pkg::DATA_W-1:0]    pwdata,
  output logic [saes_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     opcode,
  input  logic [saes_pkg::BLOCK_W-1:0]   data_in,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [saes_pkg::BLOCK_W-1:0]   data_out
);

  logic [saes_pkg::BLOCK_W-1:0] key_first;
  logic [saes_pkg::BLOCK_W-1:0] key_second;
  saes_pkg::round_keys_t        rk_first;
  saes_pkg::round_keys_t        rk_second;

  logic                         s1_valid;
  saes_pkg::op_t                s1_opcode;
  logic [saes_pkg::BLOCK_W-1:0] s1_data;

  logic                         cfg_write;
  logic                         in_accept;
  logic                         s1_advance;
  logic [saes_pkg::BLOCK_W-1:0] enc_first;
  logic [saes_pkg::BLOCK_W-1:0] dec_first;
  logic [saes_pkg::BLOCK_W-1:0] enc_second;
  logic [saes_pkg::BLOCK_W-1:0] dec_second;
  logic [saes_pkg::BLOCK_W-1:0] enc_third;
  logic [saes_pkg::BLOCK_W-1:0] data_out_next;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_first  <= '0;
      key_second <= '0;
      rk_first   <= saes_pkg::expand_key('0);
      rk_second  <= saes_pkg::expand_key('0);
    end else if (cfg_write) begin
      case (paddr[2])
        saes_pkg::REG_KEY_FIRST: begin
          key_first <= pwdata[saes_pkg::BLOCK_W-1:0];
          rk_first  <= saes_pkg::expand_key(pwdata[saes_pkg::BLOCK_W-1:0]);
        end
        saes_pkg::REG_KEY_SECOND: begin
          key_second <= pwdata[saes_pkg::BLOCK_W-1:0];
          rk_second  <= saes_pkg::expand_key(pwdata[saes_pkg::BLOCK_W-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      saes_pkg::REG_KEY_FIRST:  prdata = {{(saes_pkg::DATA_W-saes_pkg::BLOCK_W){1'b0}},
                                          key_first};
      saes_pkg::REG_KEY_SECOND: prdata = {{(saes_pkg::DATA_W-saes_pkg::BLOCK_W){1'b0}},
                                          key_second};
      default:                  prdata = '0;
    endcase
  end

  // handshake: input register moves on when the result register is empty or being taken
  assign s1_advance = !out_valid || !out_stall;
  assign in_stall   = s1_valid && !s1_advance;
  assign in_accept  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_opcode <= saes_pkg::op_t'(opcode);
      s1_data   <= data_in;
    end
  end

  // cipher passes
  assign enc_first  = saes_pkg::encrypt(s1_data, rk_first);
  assign dec_first  = saes_pkg::decrypt(s1_data, rk_first);
  assign enc_second = saes_pkg::encrypt(enc_first, rk_second);
  assign dec_second = saes_pkg::decrypt(enc_first, rk_second);
  assign enc_third  = saes_pkg::encrypt(dec_second, rk_first);

  always_comb begin
    case (s1_opcode)
      saes_pkg::OP_ENC:    data_out_next = enc_first;
      saes_pkg::OP_DEC:    data_out_next = dec_first;
      saes_pkg::OP_DOUBLE: data_out_next = enc_second;
      saes_pkg::OP_TRIPLE: data_out_next = enc_third;
      default:             data_out_next = enc_first;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid) begin
      data_out <= data_out_next;
    end
  end

`ifndef SYNTHESIS
  // an accepted beat always lands in the input register
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> s1_valid)
    else $error("accepted beat not held in input register");

  // a held beat moves to an empty result register
  a_advance: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_valid |=> out_valid)
    else $error("input beat did not move to result register");

  // stall only when both registers are full and the result is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled without a full pipeline");

  // nothing is shown right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !s1_valid)
    else $error("beat present after reset");
`endif

endmodule
